// ----- hw/rtl/ipsh_pkg.sv -----
`default_nettype none

package ipsh_pkg;

	localparam int unsigned TEMP_W  = 10;
	localparam int unsigned MEAS_W  = 16;
	localparam int unsigned GAIN_W  = 16;
	localparam int unsigned ERR_W   = 11;
	localparam int unsigned ACC_W   = 12;
	localparam int unsigned LEVEL_W = 7;
	localparam int unsigned STEP_W  = 6;
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	localparam logic [TEMP_W-1:0]  TEMP_MAX    = 10'd999;
	localparam logic [ACC_W-1:0]   ACC_MAX     = 12'd3999;
	localparam logic [LEVEL_W-1:0] PWM_PERIOD  = 7'd50;
	localparam logic [STEP_W-1:0]  PWM_LAST    = 6'd49;

	// Level is acc / 40: drop three bits, then divide by five with 205 / 1024.
	localparam logic [7:0] RECIP_FIVE = 8'd205;

	localparam logic [TEMP_W-1:0] TARGET_RST = 10'd200;
	localparam logic [GAIN_W-1:0] PROP_RST   = 16'hFF6A;
	localparam logic [GAIN_W-1:0] INTEG_RST  = 16'hFFFF;
	localparam logic [GAIN_W-1:0] DERIV_RST  = 16'h00C8;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_TARGET = 2'd0;
	localparam logic [1:0] REG_PROP   = 2'd1;
	localparam logic [1:0] REG_INTEG  = 2'd2;
	localparam logic [1:0] REG_DERIV  = 2'd3;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef struct packed {
		logic [ACC_W-1:0]          acc;
		logic signed [ERR_W-1:0]   err;
		logic [LEVEL_W-1:0]        level;
		logic [TEMP_W-1:0]         temp;
	} pid_upd_t;

endpackage

`default_nettype wire

// ----- hw/rtl/ipsh_if.sv -----
`default_nettype none

interface ipsh_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] measured_temp;

	modport source (output valid, output cmd, output measured_temp, input ready);
	modport sink   (input valid, input cmd, input measured_temp, output ready);
endinterface

interface ipsh_out_if;
	logic       valid;
	logic       ready;
	logic       heater_one_on;
	logic       heater_two_on;
	logic [6:0] drive_level;
	logic [9:0] clamped_temp;

	modport source (output valid, output heater_one_on, output heater_two_on,
		output drive_level, output clamped_temp, input ready);
	modport sink   (input valid, input heater_one_on, input heater_two_on,
		input drive_level, input clamped_temp, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/incremental_pid_split_heater_pwm.sv -----
// Incremental PID temperature loop with split PWM drive for two heaters.
// Requests arrive on sample_in: cmd 0 carries a new temperature sample,
// cmd 1 is a PWM time tick. Every request gives exactly one result on
// result_out with both heater drive bits, the heater level and the last
// clamped temperature.
// A request is held in an input register; the PID update or the PWM step
// is worked out there in a single pass, and the result is then loaded
// into the output register. One request per cycle is sustained while
// the receiver takes every result. The three gain multiplies and the
// divide by 40 sit between these two registers. If the receiver stalls,
// the result is held; the input register takes one more request if it
// is empty, and once it holds one, sample_in.ready drops until the result
// is taken. The user writes gains and the target over the APB port only
// while no request is in flight; the block does not enforce this. Reset
// (arst_n low) restores the default gains and target and clears
// accumulator, errors, level, PWM step and heater drive.
`default_nettype none

module incremental_pid_split_heater_pwm (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	ipsh_in_if.sink                            sample_in,
	ipsh_out_if.source                         result_out,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ipsh_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ipsh_pkg::DATA_W-1:0]   pwdata,
	output logic [ipsh_pkg::DATA_W-1:0]        prdata,
	output logic                               pready
);
	import ipsh_pkg::*;

	logic [TEMP_W-1:0]         target_q;
	logic signed [GAIN_W-1:0]  prop_q;
	logic signed [GAIN_W-1:0]  integ_q;
	logic signed [GAIN_W-1:0]  deriv_q;

	logic [ACC_W-1:0]          acc_q;
	logic signed [ERR_W-1:0]   err_last_q;
	logic signed [ERR_W-1:0]   err_prior_q;
	logic [LEVEL_W-1:0]        level_q;
	logic [STEP_W-1:0]         step_q;
	logic [1:0]                drive_q;
	logic [TEMP_W-1:0]         temp_q;

	logic                      valid_s1;
	logic                      cmd_s1;
	logic [MEAS_W-1:0]         meas_s1;

	logic                      out_valid_q;
	logic                      heater_one_q;
	logic                      heater_two_q;
	logic [LEVEL_W-1:0]        level_out_q;
	logic [TEMP_W-1:0]         temp_out_q;

	logic                      advance;
	logic                      cfg_write;
	pid_upd_t                  upd;
	logic [LEVEL_W-1:0]        h1_lim;
	logic [LEVEL_W-1:0]        h2_lim;
	logic [1:0]                tick_drive;
	logic [STEP_W-1:0]         tick_step;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_comb begin
		case (paddr[3:2])
			REG_TARGET: prdata = DATA_W'(target_q);
			REG_PROP:   prdata = DATA_W'(prop_q);
			REG_INTEG:  prdata = DATA_W'(integ_q);
			REG_DERIV:  prdata = DATA_W'(deriv_q);
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RST;
			prop_q   <= PROP_RST;
			integ_q  <= INTEG_RST;
			deriv_q  <= DERIV_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_TARGET: target_q <= pwdata[TEMP_W-1:0];
				REG_PROP:   prop_q   <= pwdata[GAIN_W-1:0];
				REG_INTEG:  integ_q  <= pwdata[GAIN_W-1:0];
				REG_DERIV:  deriv_q  <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign advance         = valid_s1 && (!out_valid_q || result_out.ready);
	assign sample_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_in.ready && sample_in.valid) begin
			cmd_s1  <= sample_in.cmd;
			meas_s1 <= sample_in.measured_temp;
		end
	end

	ipsh_pid_calc u_pid_calc (
		.measured_temp (meas_s1),
		.target_temp   (target_q),
		.prop_gain     (prop_q),
		.integ_gain    (integ_q),
		.deriv_gain    (deriv_q),
		.acc           (acc_q),
		.err_last      (err_last_q),
		.err_prior     (err_prior_q),
		.upd           (upd)
	);

	// Heater one takes the level up to 50, heater two the rest.
	always_comb begin
		if (level_q > PWM_PERIOD) begin
			h1_lim = PWM_PERIOD;
			h2_lim = level_q - PWM_PERIOD;
		end else begin
			h1_lim = level_q;
			h2_lim = '0;
		end
		tick_drive[0] = LEVEL_W'(step_q) < h1_lim;
		tick_drive[1] = LEVEL_W'(step_q) < h2_lim;
		tick_step     = (step_q >= PWM_LAST) ? '0 : step_q + STEP_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			err_last_q  <= '0;
			err_prior_q <= '0;
			level_q     <= '0;
			step_q      <= '0;
			drive_q     <= '0;
			temp_q      <= '0;
		end else if (advance) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				acc_q       <= upd.acc;
				err_last_q  <= upd.err;
				err_prior_q <= err_last_q;
				level_q     <= upd.level;
				temp_q      <= upd.temp;
			end else if (level_q == '0) begin
				drive_q <= '0;
			end else begin
				drive_q <= tick_drive;
				step_q  <= tick_step;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (cmd_s1 == CMD_SAMPLE) begin
				heater_one_q <= drive_q[0];
				heater_two_q <= drive_q[1];
				level_out_q  <= upd.level;
				temp_out_q   <= upd.temp;
			end else begin
				heater_one_q <= (level_q != '0) && tick_drive[0];
				heater_two_q <= (level_q != '0) && tick_drive[1];
				level_out_q  <= level_q;
				temp_out_q   <= temp_q;
			end
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.heater_one_on = heater_one_q;
	assign result_out.heater_two_on = heater_two_q;
	assign result_out.drive_level   = level_out_q;
	assign result_out.clamped_temp  = temp_out_q;

endmodule

`default_nettype wire

// ----- hw/rtl/ipsh_pid_calc.sv -----
`default_nettype none

module ipsh_pid_calc (
	input  wire logic [ipsh_pkg::MEAS_W-1:0]          measured_temp,
	input  wire logic [ipsh_pkg::TEMP_W-1:0]          target_temp,
	input  wire logic signed [ipsh_pkg::GAIN_W-1:0]   prop_gain,
	input  wire logic signed [ipsh_pkg::GAIN_W-1:0]   integ_gain,
	input  wire logic signed [ipsh_pkg::GAIN_W-1:0]   deriv_gain,
	input  wire logic [ipsh_pkg::ACC_W-1:0]           acc,
	input  wire logic signed [ipsh_pkg::ERR_W-1:0]    err_last,
	input  wire logic signed [ipsh_pkg::ERR_W-1:0]    err_prior,
	output ipsh_pkg::pid_upd_t                        upd
);
	import ipsh_pkg::*;

	localparam int unsigned DE_W  = ERR_W + 1;
	localparam int unsigned DD_W  = ERR_W + 2;
	localparam int unsigned SUM_W = GAIN_W + DD_W + 2;

	logic [TEMP_W-1:0]          temp;
	logic signed [ERR_W-1:0]    err;
	logic signed [DE_W-1:0]     d_err;
	logic signed [DD_W-1:0]     dd_err;
	logic signed [SUM_W-1:0]    p_prop;
	logic signed [SUM_W-1:0]    p_integ;
	logic signed [SUM_W-1:0]    p_deriv;
	logic signed [SUM_W-1:0]    sum;
	logic [ACC_W-1:0]           acc_new;
	logic [16:0]                quot;

	assign temp = (measured_temp > MEAS_W'(TEMP_MAX)) ? TEMP_MAX : measured_temp[TEMP_W-1:0];
	assign err  = $signed({1'b0, temp}) - $signed({1'b0, target_temp});

	assign d_err  = DE_W'(err) - DE_W'(err_last);
	assign dd_err = DD_W'(err) - (DD_W'(err_last) <<< 1) + DD_W'(err_prior);

	assign p_prop  = SUM_W'(prop_gain)  * SUM_W'(d_err);
	assign p_integ = SUM_W'(integ_gain) * SUM_W'(err);
	assign p_deriv = SUM_W'(deriv_gain) * SUM_W'(dd_err);

	assign sum = p_prop + p_integ + p_deriv + SUM_W'($signed({1'b0, acc}));

	always_comb begin
		if (sum < 0) begin
			acc_new = '0;
		end else if (sum > SUM_W'($signed({1'b0, ACC_MAX}))) begin
			acc_new = ACC_MAX;
		end else begin
			acc_new = sum[ACC_W-1:0];
		end
	end

	assign quot = 17'(acc_new[ACC_W-1:3]) * 17'(RECIP_FIVE);

	assign upd.acc   = acc_new;
	assign upd.err   = err;
	assign upd.level = quot[16:10];
	assign upd.temp  = temp;

endmodule

`default_nettype wire
